// ----- sv/plm_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and reciprocal tables for the peak level meter.
// No dependencies; imported by every module of the block.
package plm_pkg;

  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int DB_FRAC_BITS_DEF = 8;

  // configuration port
  localparam int COEFF_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam logic [COEFF_W-1:0]   FALLOFF_RESET = 16'd65234;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO    = 8'd1;

  // log2 mantissa is held in Q0.24
  localparam int TFRAC    = 24;
  localparam int POLYX_W  = 26;
  localparam int Q1_W_MAX = 27;

  // shared multiplier
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 29;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // floor(x/3)  = (x * RECIP3)  >> 29, exact for x < 2^29
  // floor(x/53) = (x * RECIP53) >> 33, exact for x < 2^27
  localparam int RECIP3_SHIFT  = 29;
  localparam int RECIP53_SHIFT = 33;
  localparam logic [63:0] RECIP3_FULL  = ((64'd1 << RECIP3_SHIFT) + 64'd2) / 64'd3;
  localparam logic [63:0] RECIP53_FULL = ((64'd1 << RECIP53_SHIFT) + 64'd52) / 64'd53;
  localparam logic [MUL_B_W-1:0] RECIP3    = RECIP3_FULL[MUL_B_W-1:0];
  localparam logic [MUL_B_W-1:0] RECIP53   = RECIP53_FULL[MUL_B_W-1:0];
  localparam logic [MUL_B_W-1:0] POLY_FOUR = MUL_B_W'(4) << TFRAC;

  typedef enum logic [1:0] {
    MUL_DECAY,
    MUL_POLY,
    MUL_DIV3,
    MUL_DIV53
  } mul_op_t;

  typedef struct packed {
    logic [MUL_A_W-1:0]  peak;
    logic [COEFF_W-1:0]  coeff;
    logic [TFRAC-1:0]    tq;
    logic [POLYX_W-1:0]  poly_x;
    logic [Q1_W_MAX-1:0] q1;
  } mul_src_t;

endpackage

// ----- sv/peak_level_meter_db_hysteresis_unit.sv -----
`timescale 1ns / 1ps
// Peak level meter top: sequencer, state registers and config port.
// Depends on plm_pkg, plm_mag and plm_mul.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in_     | input     | in_valid / in_ready   | sample_left, sample_right, last_in_block
//  out_    | output    | out_valid / out_ready | level_out (one beat per block end)
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each beat is taken while idle and folded into the peak; a beat that opens a block first
// gets a decay pass on the shared multiplier. A block end then either reports the floor
// or runs a one-bit-per-cycle leading-one search and then the polynomial, divide, scale
// and hysteresis steps on the single multiplier before the output step.
// Reset: synchronous, active low; peak and reported level 0, reported dB at -120 dB,
// block start armed. No clearing pass.
// Stalls: in_ready only while idle; a result may wait in the output register while
// the next beat goes in, and the output step holds only if one is still there.
// cfg_ready is always high; a write to an unlisted index is dropped.
module peak_level_meter_db_hysteresis_unit import plm_pkg::*; #(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int DB_FRAC_BITS = DB_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_left,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_right,
  input  logic                          in_last_in_block,
  // level output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [SAMPLE_BITS-1:0] out_level_out,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [CFG_IDX_W-1:0]   cfg_index,
  input  logic        [COEFF_W-1:0]     cfg_data
);

  // ---------------------------------------------------------------------------
  // Derived widths and constants
  // ---------------------------------------------------------------------------
  localparam int SH_W      = $clog2(SAMPLE_BITS);      // shift count, SB-1 max
  localparam int NEGL_W    = SH_W + TFRAC;             // -log2 in Q.24
  localparam int NUM_W     = NEGL_W + 10;              // -log2 * 320 + den/2
  localparam int DEN_SHIFT = TFRAC - DB_FRAC_BITS;     // den = 53 << DEN_SHIFT
  localparam int Q1_W      = NUM_W - DEN_SHIFT;
  localparam int DB_W      = DB_FRAC_BITS + 9;         // signed Q8.F plus margin
  localparam int DIFF_W    = DB_W + 1;

  localparam logic [63:0] FS_WIDE = 64'd1 << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(FS_WIDE);
  // peak * 1e6 <= full scale  <=>  peak <= floor(full scale / 1e6)
  localparam logic [SAMPLE_BITS-1:0] FLOOR_LIM = SAMPLE_BITS'(FS_WIDE / 64'd1000000);
  localparam logic signed [DB_W-1:0] DB_FLOOR =
    DB_W'(-120 * (2 ** DB_FRAC_BITS));
  localparam logic [NUM_W-1:0] HALF_DEN = NUM_W'(53 * (2 ** (DEN_SHIFT - 1)));
  // |d| * 10 > 2^F  <=>  |d| > floor(2^F / 10)
  localparam logic [DIFF_W-1:0] HYST_LIM = DIFF_W'((2 ** DB_FRAC_BITS) / 10);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECAY,
    S_MAX,
    S_FLOOR,
    S_NORM,
    S_POLY,
    S_DIV3,
    S_NEGL,
    S_SCALE,
    S_DIV53,
    S_HYST,
    S_EMIT
  } state_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                   state_r, state_nxt;
  logic [SAMPLE_BITS-1:0]   peak_r, peak_nxt;
  logic [SAMPLE_BITS-1:0]   rep_level_r, rep_level_nxt;
  logic signed [DB_W-1:0]   rep_db_r, rep_db_nxt;
  logic                     block_start_r, block_start_nxt;
  logic [COEFF_W-1:0]       coeff_r, coeff_nxt;
  logic                     stereo_r, stereo_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]   out_level_r, out_level_nxt;

  // datapath scratch, no reset
  logic [SAMPLE_BITS-1:0]   a_r, a_nxt;
  logic                     last_r, last_nxt;
  logic [SAMPLE_BITS-1:0]   norm_r, norm_nxt;
  logic [SH_W-1:0]          sh_r, sh_nxt;
  logic [POLYX_W-1:0]       polyx_r, polyx_nxt;
  logic [TFRAC-1:0]         poly_r, poly_nxt;
  logic [NEGL_W-1:0]        negl_r, negl_nxt;
  logic [Q1_W-1:0]          q1_r, q1_nxt;
  logic [DB_W-1:0]          dbmag_r, dbmag_nxt;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]   mag;
  logic [TFRAC-1:0]         tq;
  logic [NUM_W-1:0]         num;
  logic signed [DB_W-1:0]   db_new;
  logic signed [DIFF_W-1:0] db_diff;
  logic [DIFF_W-1:0]        db_abs;
  mul_op_t                  mul_op;
  mul_src_t                 mul_src;
  logic [MUL_P_W-1:0]       prod;

  plm_mag #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mag (
    .left   (in_sample_left),
    .right  (in_sample_right),
    .stereo (stereo_r),
    .mag    (mag)
  );

  // Mantissa below the leading one, moved into Q0.24.
  if (SAMPLE_BITS <= TFRAC + 1) begin : g_tq_up
    assign tq = TFRAC'(norm_r[SAMPLE_BITS-2:0]) << (TFRAC + 1 - SAMPLE_BITS);
  end else begin : g_tq_down
    assign tq = TFRAC'(norm_r[SAMPLE_BITS-2:0] >> (SAMPLE_BITS - TFRAC - 1));
  end

  always_comb begin
    mul_src        = '0;
    mul_src.peak   = MUL_A_W'(peak_r);
    mul_src.coeff  = coeff_r;
    mul_src.tq     = tq;
    mul_src.poly_x = polyx_r;
    mul_src.q1     = Q1_W_MAX'(q1_r);
  end

  plm_mul u_mul (
    .op   (mul_op),
    .src  (mul_src),
    .prod (prod)
  );

  // -log2 * 320 + den/2, with 320 = 256 + 64
  assign num = (NUM_W'(negl_r) << 8) + (NUM_W'(negl_r) << 6) + HALF_DEN;

  assign db_new  = $signed(-dbmag_r);
  assign db_diff = {db_new[DB_W-1], db_new} - {rep_db_r[DB_W-1], rep_db_r};
  assign db_abs  = db_diff[DB_W] ? DIFF_W'(-db_diff) : DIFF_W'(db_diff);

  assign in_ready      = (state_r == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_level_out = out_level_r;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    peak_nxt        = peak_r;
    rep_level_nxt   = rep_level_r;
    rep_db_nxt      = rep_db_r;
    block_start_nxt = block_start_r;
    coeff_nxt       = coeff_r;
    stereo_nxt      = stereo_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_level_nxt   = out_level_r;
    a_nxt           = a_r;
    last_nxt        = last_r;
    norm_nxt        = norm_r;
    sh_nxt          = sh_r;
    polyx_nxt       = polyx_r;
    poly_nxt        = poly_r;
    negl_nxt        = negl_r;
    q1_nxt          = q1_r;
    dbmag_nxt       = dbmag_r;
    mul_op          = MUL_DECAY;

    // config writes land whatever the sequencer is doing
    if (cfg_valid) begin
      case (cfg_index)
        CFG_FALLOFF: coeff_nxt  = cfg_data;
        CFG_STEREO:  stereo_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          a_nxt     = mag;
          last_nxt  = in_last_in_block;
          state_nxt = block_start_r ? S_DECAY : S_MAX;
        end
      end
      S_DECAY: begin
        mul_op    = MUL_DECAY;
        peak_nxt  = prod[COEFF_W +: SAMPLE_BITS];
        state_nxt = S_MAX;
      end
      S_MAX: begin
        if (a_r > peak_r) begin
          peak_nxt = a_r;
        end
        block_start_nxt = last_r;
        state_nxt       = last_r ? S_FLOOR : S_IDLE;
      end
      S_FLOOR: begin
        if (peak_r <= FLOOR_LIM) begin
          // first drop to the floor reports zero, later ones change nothing
          if (rep_db_r != DB_FLOOR) begin
            rep_level_nxt = '0;
            rep_db_nxt    = DB_FLOOR;
          end
          state_nxt = S_EMIT;
        end else begin
          norm_nxt  = peak_r;
          sh_nxt    = '0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // one bit a cycle until the leading one sits at the top
        if (norm_r[SAMPLE_BITS-1]) begin
          state_nxt = S_POLY;
        end else begin
          norm_nxt = norm_r << 1;
          sh_nxt   = SH_W'(sh_r + 1'b1);
        end
      end
      S_POLY: begin
        mul_op    = MUL_POLY;
        polyx_nxt = prod[TFRAC +: POLYX_W];
        state_nxt = S_DIV3;
      end
      S_DIV3: begin
        mul_op    = MUL_DIV3;
        poly_nxt  = prod[RECIP3_SHIFT +: TFRAC];
        state_nxt = S_NEGL;
      end
      S_NEGL: begin
        // -log2 = shift count - t(4-t)/3, positive once the shift is nonzero
        negl_nxt  = {sh_r, {TFRAC{1'b0}}} - NEGL_W'(poly_r);
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        q1_nxt    = num[NUM_W-1:DEN_SHIFT];
        state_nxt = S_DIV53;
      end
      S_DIV53: begin
        mul_op    = MUL_DIV53;
        dbmag_nxt = prod[RECIP53_SHIFT +: DB_W];
        state_nxt = S_HYST;
      end
      S_HYST: begin
        if (db_abs > HYST_LIM) begin
          rep_level_nxt = peak_r;
          rep_db_nxt    = db_new;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_level_nxt = rep_level_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      peak_r        <= '0;
      rep_level_r   <= '0;
      rep_db_r      <= DB_FLOOR;
      block_start_r <= 1'b1;
      coeff_r       <= FALLOFF_RESET;
      stereo_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      peak_r        <= peak_nxt;
      rep_level_r   <= rep_level_nxt;
      rep_db_r      <= rep_db_nxt;
      block_start_r <= block_start_nxt;
      coeff_r       <= coeff_nxt;
      stereo_r      <= stereo_nxt;
      out_valid_r   <= out_valid_nxt;
      out_level_r   <= out_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    last_r  <= last_nxt;
    norm_r  <= norm_nxt;
    sh_r    <= sh_nxt;
    polyx_r <= polyx_nxt;
    poly_r  <= poly_nxt;
    negl_r  <= negl_nxt;
    q1_r    <= q1_nxt;
    dbmag_r <= dbmag_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the leading-one search only runs on a nonzero word
  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM) |-> (norm_r != '0))
    else $error("leading-one search started on zero");

  // reported dB is never above 0 dB
  a_db_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_db_r <= 0))
    else $error("reported dB went positive");

  // decay and max never push the peak past full scale
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    (peak_r <= FULL_SCALE))
    else $error("peak above full scale");

  // leaving the output step always presents the reported level
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && (state_nxt == S_IDLE) |=>
      out_valid_r && (out_level_r == $past(rep_level_r)))
    else $error("block end result not loaded");

endmodule

// ----- sv/plm_mag.sv -----
`timescale 1ns / 1ps
// Sample magnitude: |left| in mono, |left + right| / 2 (truncated) in stereo.
// Depends on plm_pkg.
module plm_mag import plm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0] left,
  input  logic signed [SAMPLE_BITS-1:0] right,
  input  logic                          stereo,
  output logic        [SAMPLE_BITS-1:0] mag
);

  logic [SAMPLE_BITS:0] sum;
  logic [SAMPLE_BITS:0] sum_abs;
  logic [SAMPLE_BITS:0] left_ext;
  logic [SAMPLE_BITS:0] left_abs;

  always_comb begin
    sum      = {left[SAMPLE_BITS-1], left} + {right[SAMPLE_BITS-1], right};
    sum_abs  = sum[SAMPLE_BITS] ? (~sum + 1'b1) : sum;
    left_ext = {left[SAMPLE_BITS-1], left};
    left_abs = left_ext[SAMPLE_BITS] ? (~left_ext + 1'b1) : left_ext;
    // full-scale negative gives exactly 2^(SAMPLE_BITS-1), which still fits
    if (stereo) begin
      mag = sum_abs[SAMPLE_BITS:1];
    end else begin
      mag = left_abs[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ----- sv/plm_mul.sv -----
`timescale 1ns / 1ps
// Shared 32x29 multiplier with operand select for decay, polynomial and
// reciprocal divides. Depends on plm_pkg.
module plm_mul import plm_pkg::*; (
  input  mul_op_t            op,
  input  mul_src_t           src,
  output logic [MUL_P_W-1:0] prod
);

  logic [MUL_A_W-1:0] opa;
  logic [MUL_B_W-1:0] opb;

  always_comb begin
    case (op)
      MUL_DECAY: begin
        opa = src.peak;
        opb = MUL_B_W'(src.coeff);
      end
      MUL_POLY: begin
        // t * (4 - t), Q0.24 by Q3.24
        opa = MUL_A_W'(src.tq);
        opb = POLY_FOUR - MUL_B_W'(src.tq);
      end
      MUL_DIV3: begin
        opa = MUL_A_W'(src.poly_x);
        opb = RECIP3;
      end
      MUL_DIV53: begin
        opa = MUL_A_W'(src.q1);
        opb = RECIP53;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = MUL_P_W'(opa) * MUL_P_W'(opb);

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for peak_level_meter_db_hysteresis_unit: sample beats in, block levels out.
// Depends on plm_pkg and the RTL under sv/; a scoreboard class predicts and checks each level.
module testbench;
  import plm_pkg::*;

  localparam int SB  = SAMPLE_BITS_DEF;
  localparam int DBF = DB_FRAC_BITS_DEF;

  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam longint unsigned FULL_SCALE  = 64'd1 << (SB - 1);
  localparam longint unsigned SAMPLE_MASK = (64'd1 << SB) - 64'd1;
  localparam longint DB_FLOOR  = -120 * (longint'(1) << DBF);
  localparam longint HYST_STEP = longint'(1) << DBF;   // 0.1 dB, scaled by 10

  // unlisted register indexes; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 8'hFF;

  // leave margin for a block conversion to finish before a register write
  localparam int SETTLE_CYCLES      = 2 * SB + 20;
  localparam int FINAL_DRAIN_LIMIT  = 5000;
  localparam int HOLDOFF_CYCLES     = 400;
  localparam int N_PHASES           = 8;
  localparam int RANDOM_PHASE_BEATS = 190;
  localparam longint WATCHDOG_NS    = 5_000_000;

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 last;
  } sample_beat_t;

  typedef enum int {SHAPE_TINY, SHAPE_STEADY, SHAPE_SPREAD} block_shape_t;

  // Tracks peak, reported dB and reported level; queues the level each block end yields.
  class level_tracker_t;
    logic [COEFF_W-1:0] falloff;
    logic               stereo;
    longint unsigned    peak;
    longint             rep_db;
    logic [SB-1:0]      rep_level;
    bit                 blk_start;
    logic [SB-1:0]      pending_levels[$];
    int errors, beats, levels_checked, reg_writes, floor_blocks, held_blocks;

    function void reset_state();
      falloff   = FALLOFF_RESET;
      stereo    = 1'b0;
      peak      = 0;
      rep_db    = DB_FLOOR;
      rep_level = '0;
      blk_start = 1'b1;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] data);
      reg_writes++;
      if (idx == CFG_FALLOFF) falloff = data;
      else if (idx == CFG_STEREO) stereo = data[0];
    endfunction

    // Q8.DBF dB of a peak above the floor: leading-one log2 plus t*(4-t)/3, times 320/53
    function longint peak_db(longint unsigned p);
      int k;
      longint unsigned rem, tq, poly, negl, num, den;
      longint l2;
      k = SB - 1;
      while (k > 0 && ((p >> k) & 64'd1) == 0) k--;
      rem = p - (64'd1 << k);
      if (k >= TFRAC) tq = rem >> (k - TFRAC);
      else tq = rem << (TFRAC - k);
      poly = ((tq * ((64'd4 << TFRAC) - tq)) >> TFRAC) / 64'd3;
      l2 = longint'(k - (SB - 1)) * (longint'(1) << TFRAC) + longint'(poly);
      if (l2 >= 0) return 0;
      negl = longint'(-l2);
      den  = 64'd53 << (TFRAC - DBF);
      num  = negl * 64'd320 + den / 64'd2;   // round half away from zero
      return -longint'(num / den);
    endfunction

    function void absorb_sample(sample_beat_t b);
      longint lv, rv, sum, db, d;
      longint unsigned mag;
      beats++;
      lv = b.left;
      rv = b.right;
      if (stereo) begin
        sum = lv + rv;
        mag = (sum < 0) ? -sum : sum;
        mag = mag >> 1;
      end else begin
        mag = (lv < 0) ? -lv : lv;
      end
      if (blk_start) peak = (peak * falloff) >> 16;
      if (mag > peak) peak = mag;
      peak = peak & SAMPLE_MASK;
      blk_start = b.last;
      if (!b.last) return;
      if (peak * 64'd1000000 <= FULL_SCALE) begin
        floor_blocks++;
        if (rep_db != DB_FLOOR) begin
          rep_level = '0;
          rep_db    = DB_FLOOR;
        end
      end else begin
        db = peak_db(peak);
        d  = db - rep_db;
        if (d < 0) d = -d;
        if (d * 10 > HYST_STEP) begin
          rep_level = peak[SB-1:0];
          rep_db    = db;
        end else begin
          held_blocks++;
        end
      end
      pending_levels.push_back(rep_level);
    endfunction

    function void check_level(logic [SB-1:0] actual);
      logic [SB-1:0] want;
      if (pending_levels.size() == 0) begin
        errors++;
        $error("level_out beat with no block end pending: got %0d", actual);
        return;
      end
      want = pending_levels.pop_front();
      levels_checked++;
      if (actual !== want) begin
        errors++;
        $error("level_out mismatch: expected %0d, actual %0d", want, actual);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [SB-1:0] in_sample_left;
  logic signed [SB-1:0] in_sample_right;
  logic                 in_last_in_block;
  logic                 out_valid;
  logic                 out_ready;
  logic        [SB-1:0] out_level_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEFF_W-1:0]   cfg_data;

  level_tracker_t tracker;
  bit no_idle;            // one phase runs both sides flat out
  bit holdoff_request;    // asks the receiver for a long stall

  peak_level_meter_db_hysteresis_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_left   (in_sample_left),
    .in_sample_right  (in_sample_right),
    .in_last_in_block (in_last_in_block),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_level_out    (out_level_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: drives out_ready at the falling edge, takes beats at the rising edge.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        stall_left      = HOLDOFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = no_idle || ($urandom_range(99) >= 12);
      end
      @(posedge clk);
      if (out_valid && out_ready) tracker.check_level(out_level_out);
    end
  end

  function automatic sample_beat_t beat(logic signed [SB-1:0] l, logic signed [SB-1:0] r,
                                        logic last);
    sample_beat_t b;
    b.left  = l;
    b.right = r;
    b.last  = last;
    return b;
  endfunction

  function automatic logic signed [SB-1:0] pick_sample(block_shape_t shape, int shift,
                                                        int steady);
    logic signed [SB-1:0] v;
    logic signed [31:0]   r;
    int                   mag;
    case (shape)
      SHAPE_TINY: begin
        // magnitudes around the -120 dB floor (8 is the last one at it)
        mag = $urandom_range(12);
        v   = SB'(mag);
        if ($urandom_range(1)) v = -v;
      end
      SHAPE_STEADY: begin
        // near-constant level, so the reported value mostly holds
        mag = steady + $urandom_range(steady >> 10);
        if (mag > int'(SAMPLE_MAX)) mag = int'(SAMPLE_MAX);
        v = SB'(mag);
        if ($urandom_range(1)) v = -v;
      end
      default: begin
        r = $urandom;
        v = SB'(r >>> (32 - SB + shift));
        if ($urandom_range(99) < 4) v = $urandom_range(1) ? SAMPLE_MIN : SAMPLE_MAX;
      end
    endcase
    return v;
  endfunction

  // One input beat; an occasional gap first, then hold valid until taken.
  task automatic send_sample(sample_beat_t b);
    if (!no_idle && $urandom_range(99) < 12) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(2)) @(negedge clk);
    end
    @(negedge clk);
    in_valid         = 1'b1;
    in_sample_left   = b.left;
    in_sample_right  = b.right;
    in_last_in_block = b.last;
    do @(posedge clk); while (!in_ready);
    tracker.absorb_sample(b);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop offering beats until every pending level has come back.
  task automatic drain_levels();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic reconfigure(logic [COEFF_W-1:0] coeff, logic [COEFF_W-1:0] stereo_word,
                             bit spare);
    drain_levels();
    // a non-final beat may still be in the sequencer with nothing pending
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_FALLOFF, coeff);
    write_reg(CFG_STEREO, stereo_word);
    if (spare) write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, COEFF_W'($urandom));
  endtask

  task automatic directed_beats();
    // reset settings: mono, default falloff
    send_sample(beat(0, SAMPLE_MAX, 1'b1));            // floor at reset, nothing changes
    send_sample(beat(SAMPLE_MIN, SAMPLE_MIN, 1'b1));   // full-scale negative, 0 dB
    send_sample(beat(SAMPLE_MAX, 0, 1'b0));
    send_sample(beat(1, SAMPLE_MIN, 1'b0));
    send_sample(beat(-5, SAMPLE_MAX, 1'b1));           // tiny change, held

    // falloff 0, so the peak restarts each block: floor entry, floor hold, hysteresis around 0.1 dB
    reconfigure(16'd0, 16'd0, 1'b0);
    send_sample(beat(8, 0, 1'b1));
    send_sample(beat(-8, 0, 1'b1));
    send_sample(beat(9, 0, 1'b1));
    send_sample(beat(1000, 0, 1'b1));
    send_sample(beat(-1005, 0, 1'b1));
    send_sample(beat(1020, 0, 1'b1));
    send_sample(beat(3, 0, 1'b0));
    send_sample(beat(-2, 0, 1'b0));
    send_sample(beat(0, 0, 1'b1));

    // stereo, upper data bits set, plus a dropped write to an unlisted index
    reconfigure(16'd0, 16'hFFFF, 1'b1);
    send_sample(beat(SAMPLE_MIN, SAMPLE_MIN, 1'b1));   // |sum| halved is full scale
    send_sample(beat(SAMPLE_MAX, SAMPLE_MIN, 1'b1));   // sum of -1 halves to 0
    send_sample(beat(SAMPLE_MAX, SAMPLE_MAX, 1'b1));
    send_sample(beat(-3, 0, 1'b0));                    // fraction dropped after abs
    send_sample(beat(3, -6, 1'b0));
    send_sample(beat(SAMPLE_MIN, SAMPLE_MAX, 1'b1));
  endtask

  task automatic random_phase(int n_beats, bit holdoff, bit pause);
    int           sent;
    int           len;
    int           shift;
    int           steady;
    int           pick;
    block_shape_t shape;
    sample_beat_t b;
    sent   = 0;
    steady = 4096;
    while (sent < n_beats) begin
      pick = $urandom_range(99);
      if (pick < 15) len = 1;
      else if (pick < 80) len = $urandom_range(2, 6);
      else len = $urandom_range(7, 32);
      pick  = $urandom_range(99);
      shift = $urandom_range(SB - 1);
      if (pick < 10) begin
        shape = SHAPE_TINY;
      end else if (pick < 35) begin
        shape = SHAPE_STEADY;
        if ($urandom_range(3) == 0)
          steady = $urandom_range(int'(SAMPLE_MAX), 9) >> $urandom_range(20);
      end else begin
        shape = SHAPE_SPREAD;
      end
      for (int i = 0; i < len; i++) begin
        b.left = pick_sample(shape, shift, steady);
        if (!tracker.stereo) b.right = SB'($urandom);
        else if (shape == SHAPE_STEADY && $urandom_range(1)) b.right = b.left;
        else b.right = pick_sample(shape, shift, steady);
        b.last = (i == len - 1);
        if (sent == n_beats / 2) begin
          if (holdoff) holdoff_request = 1'b1;   // receiver stalls, input backs up
          if (pause) drain_levels();
        end
        send_sample(b);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [COEFF_W-1:0] coeff;
    bit                 stereo_on;
    int                 waited;
    int                 left_over;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_sample_left   = '0;
    in_sample_right  = '0;
    in_last_in_block = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_FALLOFF;
    cfg_data         = '0;
    no_idle          = 1'b0;
    holdoff_request  = 1'b0;
    tracker          = new();
    tracker.reset_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_beats();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin coeff = FALLOFF_RESET; stereo_on = 1'b0; end
        1:       begin coeff = 16'd0;         stereo_on = 1'b1; end
        2:       begin coeff = 16'hFFFF;      stereo_on = 1'b0; end
        4:       begin coeff = 16'hFFFF;      stereo_on = 1'b1; end
        6:       begin coeff = 16'd0;         stereo_on = 1'b0; end
        default: begin coeff = COEFF_W'($urandom); stereo_on = p[0]; end
      endcase
      reconfigure(coeff, (COEFF_W'($urandom) & 16'hFFFE) | COEFF_W'(stereo_on), p[0]);
      no_idle = (p == 2);
      random_phase(RANDOM_PHASE_BEATS, p == 0 || p == 3, p == 1 || p == 5);
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_valid = 1'b0;
    waited   = 0;
    while (tracker.pending_levels.size() != 0 && waited < FINAL_DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    left_over = tracker.pending_levels.size();
    if (left_over != 0) begin
      tracker.errors += left_over;
      $error("%0d block levels never came out", left_over);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d sample beats (mono and stereo), %0d block levels compared",
             tracker.beats, tracker.levels_checked);
    $display("  %0d floor blocks, %0d held by hysteresis, %0d register writes",
             tracker.floor_blocks, tracker.held_blocks, tracker.reg_writes);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
